// ===== hw/rtl/tid_pkg.sv =====
// Shared types and constants for the tile image difference block.
// No dependencies; imported by every module of the block.
package tid_pkg;

  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;
  localparam int MAX_TILE_DEF   = 64;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 13;
  localparam int TILE_CFG_W  = 7;
  localparam int IMG_CFG_W   = 13;
  localparam int PIX_W       = 8;
  localparam int COORD_W     = 12;

  localparam logic [CFG_INDEX_W-1:0] REG_TILE_WIDTH   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TILE_HEIGHT  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd3;

  localparam logic [TILE_CFG_W-1:0] TILE_WIDTH_RST   = 7'd3;
  localparam logic [TILE_CFG_W-1:0] TILE_HEIGHT_RST  = 7'd3;
  localparam logic [IMG_CFG_W-1:0]  IMAGE_WIDTH_RST  = 13'd640;
  localparam logic [IMG_CFG_W-1:0]  IMAGE_HEIGHT_RST = 13'd480;

  typedef struct packed {
    logic [TILE_CFG_W-1:0] tile_width;
    logic [TILE_CFG_W-1:0] tile_height;
    logic [IMG_CFG_W-1:0]  image_width;
    logic [IMG_CFG_W-1:0]  image_height;
  } cfg_t;

  // Per-pixel step info handed from the scan counters to the band stage.
  typedef struct packed {
    logic [COORD_W-1:0] tile_x;
    logic [COORD_W-1:0] tile_y;
    logic               seg_end;   // pixel closes a row segment of its tile
    logic               emit;      // pixel closes the whole tile
    logic               use_band;  // merge with the flag of earlier tile rows
    logic               seg_flag;  // difference seen in this segment so far
    logic               last;      // final tile of the frame
  } step_t;

endpackage

// ===== hw/rtl/tid_cfg_regs.sv =====
// Configuration register file for the tile image difference block.
// Depends on tid_pkg.
module tid_cfg_regs
  import tid_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tile_width   <= TILE_WIDTH_RST;
      cfg.tile_height  <= TILE_HEIGHT_RST;
      cfg.image_width  <= IMAGE_WIDTH_RST;
      cfg.image_height <= IMAGE_HEIGHT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TILE_WIDTH:   cfg.tile_width   <= cfg_data[TILE_CFG_W-1:0];
        REG_TILE_HEIGHT:  cfg.tile_height  <= cfg_data[TILE_CFG_W-1:0];
        REG_IMAGE_WIDTH:  cfg.image_width  <= cfg_data[IMG_CFG_W-1:0];
        REG_IMAGE_HEIGHT: cfg.image_height <= cfg_data[IMG_CFG_W-1:0];
      endcase
    end
  end

endmodule

// ===== hw/rtl/tid_scan.sv =====
// Raster scan counters and per-pixel difference detect.
// Depends on tid_pkg; feeds step info and tile column index to tid_band.
module tid_scan
  import tid_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int MAX_TILE   = MAX_TILE_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cfg_t                         cfg,
  input  logic                         accept,
  input  logic [6*PIX_W-1:0]           pixels,
  output step_t                        step,
  output logic [$clog2(MAX_WIDTH)-1:0] col_idx
);

  localparam int WW = $clog2(MAX_WIDTH);
  localparam int HW = $clog2(MAX_HEIGHT);
  localparam int TB = $clog2(MAX_TILE);
  localparam int WD = WW + 1;
  localparam int HD = HW + 1;
  localparam int TD = TB + 1;

  logic [WW-1:0] pixel_column, pixel_column_next;
  logic [HW-1:0] pixel_row, pixel_row_next;
  logic [TB-1:0] column_in_tile, column_in_tile_next;
  logic [TB-1:0] row_in_tile, row_in_tile_next;
  logic [WW-1:0] tile_column_count, tile_column_count_next;
  logic [HW-1:0] tile_row_count, tile_row_count_next;
  logic          segment_flag;

  logic [TD-1:0] tw, th;
  logic [WD-1:0] iw;
  logic [HD-1:0] ih;
  logic          diff, row_end, frame_row_end, seg_end, tile_bottom, seg_flag_new;

  // Out-of-range sizes: zero acts as one, oversize acts as the maximum.
  always_comb begin
    if (cfg.tile_width == '0)                tw = TD'(1);
    else if (32'(cfg.tile_width) > MAX_TILE) tw = TD'(MAX_TILE);
    else                                     tw = TD'(cfg.tile_width);
    if (cfg.tile_height == '0)                th = TD'(1);
    else if (32'(cfg.tile_height) > MAX_TILE) th = TD'(MAX_TILE);
    else                                      th = TD'(cfg.tile_height);
    if (cfg.image_width == '0)                 iw = WD'(1);
    else if (32'(cfg.image_width) > MAX_WIDTH) iw = WD'(MAX_WIDTH);
    else                                       iw = WD'(cfg.image_width);
    if (cfg.image_height == '0)                  ih = HD'(1);
    else if (32'(cfg.image_height) > MAX_HEIGHT) ih = HD'(MAX_HEIGHT);
    else                                         ih = HD'(cfg.image_height);
  end

  always_comb begin
    diff          = pixels[3*PIX_W-1:0] != pixels[6*PIX_W-1:3*PIX_W];
    row_end       = (WD'(pixel_column) + WD'(1)) >= iw;
    frame_row_end = (HD'(pixel_row) + HD'(1)) >= ih;
    seg_end       = row_end || ((TD'(column_in_tile) + TD'(1)) >= tw);
    tile_bottom   = frame_row_end || ((TD'(row_in_tile) + TD'(1)) >= th);
    seg_flag_new  = (column_in_tile == '0) ? diff : (segment_flag || diff);

    step.tile_x   = COORD_W'(tile_column_count);
    step.tile_y   = COORD_W'(tile_row_count);
    step.seg_end  = seg_end;
    step.emit     = seg_end && tile_bottom;
    step.use_band = row_in_tile != '0;
    step.seg_flag = seg_flag_new;
    step.last     = row_end && frame_row_end;
    col_idx       = tile_column_count;
  end

  always_comb begin
    pixel_column_next      = pixel_column;
    pixel_row_next         = pixel_row;
    column_in_tile_next    = column_in_tile;
    row_in_tile_next       = row_in_tile;
    tile_column_count_next = tile_column_count;
    tile_row_count_next    = tile_row_count;
    if (row_end) begin
      pixel_column_next      = '0;
      column_in_tile_next    = '0;
      tile_column_count_next = '0;
      if (frame_row_end) begin
        pixel_row_next      = '0;
        row_in_tile_next    = '0;
        tile_row_count_next = '0;
      end else begin
        pixel_row_next = pixel_row + HW'(1);
        if (tile_bottom) begin
          row_in_tile_next    = '0;
          tile_row_count_next = tile_row_count + HW'(1);
        end else begin
          row_in_tile_next = row_in_tile + TB'(1);
        end
      end
    end else begin
      pixel_column_next = pixel_column + WW'(1);
      if (seg_end) begin
        column_in_tile_next    = '0;
        tile_column_count_next = tile_column_count + WW'(1);
      end else begin
        column_in_tile_next = column_in_tile + TB'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_column      <= '0;
      pixel_row         <= '0;
      column_in_tile    <= '0;
      row_in_tile       <= '0;
      tile_column_count <= '0;
      tile_row_count    <= '0;
      segment_flag      <= 1'b0;
    end else if (accept) begin
      pixel_column      <= pixel_column_next;
      pixel_row         <= pixel_row_next;
      column_in_tile    <= column_in_tile_next;
      row_in_tile       <= row_in_tile_next;
      tile_column_count <= tile_column_count_next;
      tile_row_count    <= tile_row_count_next;
      segment_flag      <= seg_flag_new;
    end
  end

endmodule

// ===== hw/rtl/tid_band.sv =====
// Band flag store (one bit per tile column) and the stage that merges it.
// Depends on tid_pkg; step info comes from tid_scan.
module tid_band
  import tid_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  step_t                        step,
  input  logic [$clog2(MAX_WIDTH)-1:0] col_idx,
  input  logic                         go,
  output logic                         busy,
  output step_t                        held,
  output logic                         differs
);

  localparam int WW = $clog2(MAX_WIDTH);

  logic          band_mem [MAX_WIDTH];
  logic          busy_next;
  logic [WW-1:0] held_idx;
  logic          rd_flag;
  logic          byp_hit;
  logic          byp_flag;
  logic          band_flag;
  logic          wr_en;

  // A write from the item ahead lands at the same edge as this item's read,
  // so that value is forwarded instead of the stale read.
  assign band_flag = byp_hit ? byp_flag : rd_flag;
  assign differs   = held.seg_flag || (held.use_band && band_flag);
  assign wr_en     = go && held.seg_end;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      band_mem[held_idx] <= differs;
    end
    if (accept) begin
      rd_flag <= band_mem[col_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held     <= step;
      held_idx <= col_idx;
      byp_hit  <= wr_en && (held_idx == col_idx);
      byp_flag <= differs;
    end
  end

  always_comb begin
    busy_next = busy;
    if (accept)  busy_next = 1'b1;
    else if (go) busy_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= busy_next;
    end
  end

endmodule

// ===== hw/rtl/tile_image_difference.sv =====
// Tile image difference: top level with handshakes and result register.
// Depends on tid_pkg, tid_cfg_regs, tid_scan and tid_band.
//
// Usage: pixel pairs of two RGB frames enter in raster order on the s_ beats,
// one pair per beat. The frame is cut into tiles of the configured size, with
// clipped tiles at the right and bottom edges. The pixel that closes a tile
// yields one m_ beat with its tile column and row, a flag that is set when any
// channel of any pixel in the tile differed, and tlast on the frame's final
// tile. Other pixels yield no beat.
// Throughput: one pixel per cycle while the merge stage is not stalled; the
// per-column band flag memory is read when a pixel is taken and written when
// the pixel leaves the merge stage, with a forward path for back-to-back hits
// on the same column. A result is registered as its pixel leaves the merge stage.
// Stall: while the result register holds an untaken beat, a pixel that closes
// another tile waits in the merge stage and s_tready drops; pixels that close
// no tile keep flowing.
// Reset: counters clear to the frame origin, registers to 3x3 tiles in a
// 640x480 frame. The user writes cfg_* registers only while idle; not enforced.
module tile_image_difference
  import tid_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int MAX_TILE   = MAX_TILE_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // red_a, green_a, blue_a, red_b, green_b, blue_b (8 bits each, from bit 0)
  input  logic [6*PIX_W-1:0]     s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // tile_x [11:0], tile_y [23:12]
  output logic [2*COORD_W-1:0]   m_tdata,
  // tile_differs [0]
  output logic                   m_tuser,
  output logic                   m_tlast
);

  cfg_t                         cfg;
  step_t                        step;
  step_t                        held;
  logic [$clog2(MAX_WIDTH)-1:0] col_idx;
  logic                         accept;
  logic                         go;
  logic                         busy;
  logic                         differs;
  logic                         load;

  tid_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tid_scan #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_TILE   (MAX_TILE)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .accept  (accept),
    .pixels  (s_tdata),
    .step    (step),
    .col_idx (col_idx)
  );

  tid_band #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_band (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .step    (step),
    .col_idx (col_idx),
    .go      (go),
    .busy    (busy),
    .held    (held),
    .differs (differs)
  );

  assign go       = busy && (!held.emit || !m_tvalid || m_tready);
  assign s_tready = !busy || go;
  assign accept   = s_tvalid && s_tready;
  assign load     = go && held.emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {held.tile_y, held.tile_x};
      m_tuser <= differs;
      m_tlast <= held.last;
    end
  end

endmodule

// ===== sim/tb_tile_image_difference.sv =====
// Self-checking testbench for tile_image_difference: drives pixel-pair beats,
// predicts every tile result with a scoreboard model and compares each m_ beat.
// Depends on tid_pkg and the tile_image_difference RTL.
module tb_tile_image_difference;
  import tid_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 4;
  // band flag entries seeded up front; random frames stay within this width
  localparam int BAND_COLS = 256;
  localparam int RANDOM_PIXELS = 740;

  typedef struct packed {
    logic [PIX_W-1:0] blue_b;
    logic [PIX_W-1:0] green_b;
    logic [PIX_W-1:0] red_b;
    logic [PIX_W-1:0] blue_a;
    logic [PIX_W-1:0] green_a;
    logic [PIX_W-1:0] red_a;
  } pixel_pair_t;

  typedef struct packed {
    logic [COORD_W-1:0] tile_x;
    logic [COORD_W-1:0] tile_y;
    logic               differs;
    logic               last;
  } tile_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [6*PIX_W-1:0]     s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b1;
  logic [2*COORD_W-1:0]   m_tdata;
  logic                   m_tuser;
  logic                   m_tlast;

  tile_image_difference u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Tile model: register copies and scan state
  logic [TILE_CFG_W-1:0] tile_w_cfg = TILE_WIDTH_RST;
  logic [TILE_CFG_W-1:0] tile_h_cfg = TILE_HEIGHT_RST;
  logic [IMG_CFG_W-1:0]  img_w_cfg  = IMAGE_WIDTH_RST;
  logic [IMG_CFG_W-1:0]  img_h_cfg  = IMAGE_HEIGHT_RST;

  int unsigned px_col = 0, px_row = 0;
  int unsigned col_in_tile = 0, row_in_tile = 0;
  int unsigned tile_col = 0, tile_row = 0;
  bit          seg_diff = 1'b0;
  bit          band_diff [MAX_WIDTH_DEF];

  tile_result_t expected_tiles [$];
  int unsigned  error_count = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  ready_hold = 0;

  function automatic int unsigned fit_range(input int unsigned v, input int unsigned hi);
    return (v < 1) ? 1 : ((v > hi) ? hi : v);
  endfunction

  function automatic void step_tile_model(input pixel_pair_t p);
    int unsigned  tw, th, iw, ih;
    bit           px_diff, row_end, last_row, seg_end, tile_bottom, acc;
    tile_result_t r;
    tw = fit_range(tile_w_cfg, MAX_TILE_DEF);
    th = fit_range(tile_h_cfg, MAX_TILE_DEF);
    iw = fit_range(img_w_cfg, MAX_WIDTH_DEF);
    ih = fit_range(img_h_cfg, MAX_HEIGHT_DEF);
    px_diff = (p.red_a != p.red_b) || (p.green_a != p.green_b) || (p.blue_a != p.blue_b);
    row_end = px_col + 1 >= iw;
    last_row = px_row + 1 >= ih;
    seg_end = row_end || (col_in_tile + 1 >= tw);
    tile_bottom = last_row || (row_in_tile + 1 >= th);
    seg_diff = (col_in_tile == 0) ? px_diff : (seg_diff || px_diff);
    if (seg_end) begin
      // merge with the rows of this tile already seen in the band
      acc = seg_diff || (row_in_tile != 0 && band_diff[tile_col]);
      band_diff[tile_col] = acc;
      if (tile_bottom) begin
        r.tile_x = tile_col[COORD_W-1:0];
        r.tile_y = tile_row[COORD_W-1:0];
        r.differs = acc;
        r.last = row_end && last_row;
        expected_tiles.push_back(r);
      end
    end
    if (row_end) begin
      px_col = 0;
      col_in_tile = 0;
      tile_col = 0;
      if (last_row) begin
        px_row = 0;
        row_in_tile = 0;
        tile_row = 0;
      end else begin
        px_row++;
        if (tile_bottom) begin
          row_in_tile = 0;
          tile_row++;
        end else begin
          row_in_tile++;
        end
      end
    end else begin
      px_col++;
      if (seg_end) begin
        col_in_tile = 0;
        tile_col++;
      end else begin
        col_in_tile++;
      end
    end
  endfunction

  task automatic report_error(input string msg);
    $display("%0t ERROR %s", $time, msg);
    error_count++;
  endtask

  // Pixel beats feed the model and result beats are checked, in that order
  always @(posedge clk) begin : observe
    tile_result_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) step_tile_model(s_tdata);
      if (m_tvalid && m_tready) begin
        if (expected_tiles.size() == 0) begin
          report_error($sformatf("unexpected tile beat x=%0d y=%0d",
                                 m_tdata[COORD_W-1:0], m_tdata[2*COORD_W-1:COORD_W]));
        end else begin
          want = expected_tiles.pop_front();
          if (m_tdata[COORD_W-1:0] != want.tile_x)
            report_error($sformatf("tile_x got %0d want %0d",
                                   m_tdata[COORD_W-1:0], want.tile_x));
          if (m_tdata[2*COORD_W-1:COORD_W] != want.tile_y)
            report_error($sformatf("tile_y got %0d want %0d",
                                   m_tdata[2*COORD_W-1:COORD_W], want.tile_y));
          if (m_tuser !== want.differs)
            report_error($sformatf("tile_differs got %b want %b at tile %0d,%0d",
                                   m_tuser, want.differs, want.tile_x, want.tile_y));
          if (m_tlast !== want.last)
            report_error($sformatf("last_tile got %b want %b at tile %0d,%0d",
                                   m_tlast, want.last, want.tile_x, want.tile_y));
        end
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: alternating ready and stall stretches of random length
  always @(negedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      m_tready <= !m_tready;
      if (m_tready)
        ready_hold <= ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
                                                  : $urandom_range(0, 4);
      else
        ready_hold <= ($urandom_range(0, 5) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(0, 12);
    end
  end

  function automatic pixel_pair_t make_pair(input int permille);
    pixel_pair_t p;
    logic [3*PIX_W-1:0] flip;
    p[3*PIX_W-1:0] = (3*PIX_W)'($urandom);
    flip = '0;
    if ($urandom_range(0, 999) < permille) begin
      if ($urandom_range(0, 1) == 0) flip[$urandom_range(0, 3*PIX_W-1)] = 1'b1;
      while (flip == '0) flip = (3*PIX_W)'($urandom);
    end
    p[6*PIX_W-1:3*PIX_W] = p[3*PIX_W-1:0] ^ flip;
    return p;
  endfunction

  // Leaves s_tvalid high after the beat; the caller lowers it at the next fall
  task automatic send_pixel(input pixel_pair_t p);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= p;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic stop_pixels();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  task automatic run_pixels(input int count, input int diff_permille);
    int burst;
    int gap;
    burst = $urandom_range(1, 12);
    for (int k = 0; k < count; k++) begin
      if (burst == 0) begin
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 25) : $urandom_range(1, 3);
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
        burst = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 250) : $urandom_range(1, 12);
      end
      send_pixel(make_pair(diff_permille));
      burst--;
    end
    stop_pixels();
  endtask

  // Sender must be stopped; waits for every pending tile and the pipe to empty
  task automatic wait_idle();
    while (expected_tiles.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input bit [3:0] sel, input logic [CFG_DATA_W-1:0] tw_v,
                            input logic [CFG_DATA_W-1:0] th_v,
                            input logic [CFG_DATA_W-1:0] iw_v,
                            input logic [CFG_DATA_W-1:0] ih_v);
    logic [CFG_INDEX_W-1:0] reg_ids [4];
    logic [CFG_DATA_W-1:0]  vals [4];
    reg_ids = '{REG_TILE_WIDTH, REG_TILE_HEIGHT, REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT};
    vals = '{tw_v, th_v, iw_v, ih_v};
    wait_idle();
    for (int i = 0; i < 4; i++) begin
      if (sel[i]) begin
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= reg_ids[i];
        cfg_data <= vals[i];
        do @(posedge clk); while (!cfg_ready);
        case (reg_ids[i])
          REG_TILE_WIDTH:   tile_w_cfg = vals[i][TILE_CFG_W-1:0];
          REG_TILE_HEIGHT:  tile_h_cfg = vals[i][TILE_CFG_W-1:0];
          REG_IMAGE_WIDTH:  img_w_cfg = vals[i][IMG_CFG_W-1:0];
          REG_IMAGE_HEIGHT: img_h_cfg = vals[i][IMG_CFG_W-1:0];
          default: ;
        endcase
      end
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One row of one-pixel tiles seeds every band flag entry that later frames
  // can reach. Tile height and frame height stay at reset, so no tile closes.
  task automatic test_full_width_row();
    write_regs(4'b0101, 13'd1, 13'd0, CFG_DATA_W'(BAND_COLS), 13'd0);
    run_pixels(BAND_COLS, 20);
  endtask

  // Channel extremes in a 3x3 frame of 2x2 tiles: clipped tiles, last tile
  task automatic test_channel_extremes();
    logic [6*PIX_W-1:0] pats [18];
    pats = '{48'h000000_000000, 48'hFFFFFF_FFFFFF, 48'hFFFFFF_000000,
             48'h000001_000000, 48'h008000_000000, 48'h7F0000_FF0000,
             48'hA55AA5_A55AA5, 48'h0000FE_0000FF, 48'h123456_123456,
             48'h000000_000000, 48'hFFFFFF_FFFFFF, 48'h000000_000000,
             48'h800000_000000, 48'h000080_000000, 48'hFFFFFF_FFFFFF,
             48'h00FF00_000000, 48'hFFFF7F_FFFFFF, 48'h5A5A5A_5A5A5A};
    write_regs(4'b1111, 13'd2, 13'd2, 13'd3, 13'd3);
    foreach (pats[i]) send_pixel(pats[i]);
    stop_pixels();
  endtask

  // Out-of-range register values: zero acts as one, large values clamp,
  // tile register bits above bit 6 are dropped
  task automatic test_register_limits();
    write_regs(4'b1111, 13'h1F80, 13'h0000, 13'h0000, 13'h0000);
    run_pixels(4, 500);
    write_regs(4'b1111, 13'h007F, 13'h1FFF, 13'h1FFF, 13'h1001);
    run_pixels(6, 300);
  endtask

  // Shrinking limits mid-frame: counters past the new limits close at once
  task automatic test_midframe_change();
    write_regs(4'b1111, 13'd6, 13'd5, 13'd20, 13'd9);
    run_pixels(17, 100);
    write_regs(4'b1111, 13'd1, 13'd1, 13'd5, 13'd1);
    run_pixels(8, 300);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_setting(input bit tile_reg);
    case ($urandom_range(0, 9))
      0: return CFG_DATA_W'($urandom);
      1: return CFG_DATA_W'($urandom_range(0, 1));
      2: return CFG_DATA_W'(tile_reg ? $urandom_range(MAX_TILE_DEF, MAX_TILE_DEF + 1)
                                     : $urandom_range(MAX_WIDTH_DEF, MAX_WIDTH_DEF + 1));
      3: return CFG_DATA_W'(tile_reg ? $urandom_range(1, 16) : $urandom_range(1, 60));
      default: return CFG_DATA_W'(tile_reg ? $urandom_range(1, 5) : $urandom_range(1, 20));
    endcase
  endfunction

  task automatic test_random_frames();
    int                    rates [6];
    int                    pixels_sent;
    int                    n;
    bit [3:0]              sel;
    logic [CFG_DATA_W-1:0] iw_v;
    rates = '{0, 2, 20, 150, 600, 1000};
    pixels_sent = 0;
    sel = 4'b1111;
    while (pixels_sent < RANDOM_PIXELS) begin
      iw_v = pick_setting(1'b0);
      if (iw_v > CFG_DATA_W'(BAND_COLS)) iw_v = CFG_DATA_W'(BAND_COLS);
      write_regs(sel, pick_setting(1'b1), pick_setting(1'b1),
                 iw_v, pick_setting(1'b0));
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(150, 300) : $urandom_range(10, 80);
      run_pixels(n, rates[$urandom_range(0, 5)]);
      pixels_sent += n;
      sel = 4'($urandom_range(1, 15));
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    test_full_width_row();
    test_channel_extremes();
    test_register_limits();
    test_midframe_change();
    test_random_frames();
    wait_idle();
    repeat (20) @(posedge clk);
    if (error_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
